@@ hw/rtl/b64d_pkg.sv @@
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR      = 8'h3D;
    localparam logic [7:0] XOR_KEY_RESET = 8'h19;
    localparam logic [7:0] ADD_KEY_RESET = 8'h86;

    // result queue depth, a power of two, at least 4
    localparam int RESULT_FIFO_DEPTH = 8;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_XOR_KEY = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ADD_KEY = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_ACTIVE = 2'd0,
        ST_DONE   = 2'd1,
        ST_ERROR  = 2'd2
    } status_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    // all results caused by one character, item 0 first
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     item;
    } bundle_t;

    // bit 6 set means the character is outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [6:0] val;
        case (ch) inside
            [8'h41:8'h5A]: val = 7'(ch - 8'h41);
            [8'h61:8'h7A]: val = 7'(ch - 8'h47);
            [8'h30:8'h39]: val = 7'(ch + 8'd4);
            8'h2B:         val = 7'd62;
            8'h2F:         val = 7'd63;
            default:       val = 7'h40;
        endcase
        return val;
    endfunction

    function automatic logic [7:0] unmask(input logic [7:0] b, input logic [7:0] add_key,
                                          input logic [7:0] xor_key);
        return (b - add_key) ^ xor_key;
    endfunction

endpackage

@@ hw/rtl/b64d_decoder.sv @@
module b64d_decoder
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          char_code,
    input  logic                start_of_text,
    input  logic [7:0]          xor_key,
    input  logic [7:0]          add_key,
    output b64d_pkg::bundle_t   results
);

    logic [1:0]        pos_reg, pos_next;
    logic [17:0]       acc_reg, acc_next;
    logic [1:0]        pad_reg, pad_next;
    b64d_pkg::status_t status_reg, status_next;

    logic [1:0]        pos_eff;
    logic [17:0]       acc_eff;
    logic [1:0]        pad_eff;
    b64d_pkg::status_t status_eff;

    logic [6:0]  sx;
    logic        bad;
    logic        is_pad;
    logic        active;
    logic        group_err;
    logic [1:0]  group_pad;
    logic [23:0] word;

    // start flag clears the state before this character is handled
    assign pos_eff    = start_of_text ? 2'd0 : pos_reg;
    assign acc_eff    = start_of_text ? 18'd0 : acc_reg;
    assign pad_eff    = start_of_text ? 2'd0 : pad_reg;
    assign status_eff = start_of_text ? b64d_pkg::ST_ACTIVE : status_reg;

    assign sx        = b64d_pkg::sextet_of(char_code);
    assign bad       = sx[6];
    assign is_pad    = (char_code == b64d_pkg::PAD_CHAR);
    assign active    = (status_eff == b64d_pkg::ST_ACTIVE);
    assign group_err = !is_pad && (pad_eff != 2'd0 || bad);
    assign group_pad = is_pad ? 2'(pad_eff + 2'd1) : pad_eff;
    assign word      = {acc_eff, (is_pad ? 6'd0 : sx[5:0])};

    always_comb
    begin
        pos_next    = pos_eff;
        acc_next    = acc_eff;
        pad_next    = pad_eff;
        status_next = status_eff;
        if (active)
        begin
            case (pos_eff)
                2'd0:
                begin
                    if (bad)
                    begin
                        status_next = b64d_pkg::ST_DONE;
                    end
                    else
                    begin
                        acc_next = {12'd0, sx[5:0]};
                        pad_next = 2'd0;
                        pos_next = 2'd1;
                    end
                end
                2'd1:
                begin
                    if (bad)
                    begin
                        status_next = b64d_pkg::ST_ERROR;
                    end
                    else
                    begin
                        acc_next = {acc_eff[11:0], sx[5:0]};
                        pos_next = 2'd2;
                    end
                end
                2'd2:
                begin
                    if (is_pad)
                    begin
                        pad_next = 2'd1;
                        acc_next = {acc_eff[11:0], 6'd0};
                        pos_next = 2'd3;
                    end
                    else if (bad)
                    begin
                        status_next = b64d_pkg::ST_ERROR;
                    end
                    else
                    begin
                        acc_next = {acc_eff[11:0], sx[5:0]};
                        pos_next = 2'd3;
                    end
                end
                default:
                begin
                    if (group_err)
                    begin
                        status_next = b64d_pkg::ST_ERROR;
                    end
                    else
                    begin
                        pos_next = 2'd0;
                        acc_next = 18'd0;
                        pad_next = 2'd0;
                        // padding ends the text
                        if (group_pad != 2'd0)
                        begin
                            status_next = b64d_pkg::ST_DONE;
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        results = '0;
        if (active)
        begin
            case (pos_eff)
                2'd0:
                begin
                    if (bad)
                    begin
                        results.item[0].kind = b64d_pkg::KIND_END;
                        results.count        = 2'd1;
                    end
                end
                2'd1:
                begin
                    if (bad)
                    begin
                        results.item[0].kind = b64d_pkg::KIND_BAD;
                        results.count        = 2'd1;
                    end
                end
                2'd2:
                begin
                    if (!is_pad && bad)
                    begin
                        results.item[0].kind = b64d_pkg::KIND_BAD;
                        results.count        = 2'd1;
                    end
                end
                default:
                begin
                    if (group_err)
                    begin
                        results.item[0].kind = b64d_pkg::KIND_BAD;
                        results.count        = 2'd1;
                    end
                    else
                    begin
                        results.item[0].kind = b64d_pkg::KIND_DATA;
                        results.item[0].data = b64d_pkg::unmask(word[23:16], add_key, xor_key);
                        case (group_pad)
                            2'd0:
                            begin
                                results.item[1].kind = b64d_pkg::KIND_DATA;
                                results.item[1].data =
                                    b64d_pkg::unmask(word[15:8], add_key, xor_key);
                                results.item[2].kind = b64d_pkg::KIND_DATA;
                                results.item[2].data =
                                    b64d_pkg::unmask(word[7:0], add_key, xor_key);
                                results.count        = 2'd3;
                            end
                            2'd1:
                            begin
                                results.item[1].kind = b64d_pkg::KIND_DATA;
                                results.item[1].data =
                                    b64d_pkg::unmask(word[15:8], add_key, xor_key);
                                results.item[2].kind = b64d_pkg::KIND_END;
                                results.count        = 2'd3;
                            end
                            default:
                            begin
                                results.item[1].kind = b64d_pkg::KIND_END;
                                results.count        = 2'd2;
                            end
                        endcase
                    end
                end
            endcase
        end
        if (results.count != 2'd0)
        begin
            results.item[2'(results.count - 2'd1)].last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 2'd0;
            acc_reg    <= 18'd0;
            pad_reg    <= 2'd0;
            status_reg <= b64d_pkg::ST_ACTIVE;
        end
        else if (fire)
        begin
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            pad_reg    <= pad_next;
            status_reg <= status_next;
        end
    end

endmodule

@@ hw/rtl/b64d_result_fifo.sv @@
module b64d_result_fifo
#(
    parameter int DEPTH = b64d_pkg::RESULT_FIFO_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64d_pkg::bundle_t   push_bundle,
    output logic                space_ok,
    output logic                valid,
    input  logic                stall,
    output b64d_pkg::result_t   head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::result_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    push_n;
    logic          pop;

    assign push_n   = push ? push_bundle.count : 2'd0;
    assign pop      = valid && !stall;
    assign valid    = (count_reg != CW'(0));
    assign head     = mem[rd_ptr_reg];
    // room for a full bundle of three
    assign space_ok = (count_reg <= CW'(DEPTH - 3));

    assign wr_ptr_next = AW'(wr_ptr_reg + AW'(push_n));
    assign rd_ptr_next = pop ? AW'(rd_ptr_reg + AW'(1)) : rd_ptr_reg;
    assign count_next  = CW'(count_reg + CW'(push_n) - CW'(pop));

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < push_n)
            begin
                mem[AW'(wr_ptr_reg + AW'(i))] <= push_bundle.item[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/base64_deobfuscate_decoder_top.sv @@
// Streaming base64 decoder with byte unmasking. One character is taken per
// clock unless the input stalls; it is held in an input register, decoded
// against the group state, and the up to three results it causes (data bytes,
// end of text, or malformed input) go into a result queue of RESULT_FIFO_DEPTH
// entries that drains one result per clock when not stalled. The first result
// of a character is offered once the character has left the input register
// for the queue. The input stalls only while the queue has fewer than three
// free entries, so a complete group of four characters sustains one character
// per clock while the receiver keeps up. Registers: index 0 xor key, index 1
// add key, other indexes ignored; write them only while the block is idle.
module base64_deobfuscate_decoder_top
#(
    parameter int RESULT_FIFO_DEPTH = b64d_pkg::RESULT_FIFO_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             char_valid,
    output logic                             char_stall,
    input  logic [7:0]                       char_code,
    input  logic                             start_of_text,

    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [1:0]                       result_kind,
    output logic [7:0]                       data_byte,
    output logic                             last_of_run,

    input  logic                             cfg_write_en,
    input  logic [b64d_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [b64d_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [7:0] xor_key_reg;
    logic [7:0] add_key_reg;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       start_reg;

    logic              accept;
    logic              fire;
    logic              space_ok;
    b64d_pkg::bundle_t bundle;
    b64d_pkg::result_t head;

    assign fire          = in_valid_reg && space_ok;
    assign char_stall    = in_valid_reg && !space_ok;
    assign accept        = char_valid && !char_stall;
    assign in_valid_next = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg  <= char_code;
            start_reg <= start_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_key_reg <= b64d_pkg::XOR_KEY_RESET;
            add_key_reg <= b64d_pkg::ADD_KEY_RESET;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == b64d_pkg::REG_XOR_KEY)
            begin
                xor_key_reg <= cfg_data[7:0];
            end
            else if (cfg_index == b64d_pkg::REG_ADD_KEY)
            begin
                add_key_reg <= cfg_data[7:0];
            end
        end
    end

    b64d_decoder u_decoder
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .char_code     (char_reg),
        .start_of_text (start_reg),
        .xor_key       (xor_key_reg),
        .add_key       (add_key_reg),
        .results       (bundle)
    );

    b64d_result_fifo
    #(
        .DEPTH (RESULT_FIFO_DEPTH)
    )
    u_result_fifo
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (fire),
        .push_bundle (bundle),
        .space_ok    (space_ok),
        .valid       (result_valid),
        .stall       (result_stall),
        .head        (head)
    );

    assign result_kind = head.kind;
    assign data_byte   = head.data;
    assign last_of_run = head.last;

endmodule

@@ tb/base64_deobfuscate_decoder_top_tb.sv @@
`timescale 1ns / 100ps

module base64_deobfuscate_decoder_top_tb;

    // an index with no register behind it, writes there must change nothing
    localparam logic [b64d_pkg::CFG_INDEX_W-1:0] REG_SPARE = b64d_pkg::CFG_INDEX_W'(9);
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 80;
    localparam int TEXT_BUDGET   = 90;

    class decode_scoreboard;
        logic [7:0]        xor_key;
        logic [7:0]        add_key;
        logic [1:0]        group_pos;
        logic [17:0]       sextets;
        logic [1:0]        pads;
        b64d_pkg::status_t status;
        b64d_pkg::result_t results_due[$];
        b64d_pkg::result_t run_buf[$];
        int                failures;

        function new();
            xor_key   = b64d_pkg::XOR_KEY_RESET;
            add_key   = b64d_pkg::ADD_KEY_RESET;
            group_pos = 2'd0;
            sextets   = 18'd0;
            pads      = 2'd0;
            status    = b64d_pkg::ST_ACTIVE;
            failures  = 0;
        endfunction

        // bit 6 flags a character outside the alphabet
        static function logic [6:0] sextet_value(logic [7:0] c);
            if (c >= "A" && c <= "Z")
                return 7'(c - "A");
            if (c >= "a" && c <= "z")
                return 7'(c - "a" + 8'd26);
            if (c >= "0" && c <= "9")
                return 7'(c - "0" + 8'd52);
            if (c == "+")
                return 7'd62;
            if (c == "/")
                return 7'd63;
            return 7'h40;
        endfunction

        function void write_reg(logic [b64d_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] val);
            case (idx)
                b64d_pkg::REG_XOR_KEY: xor_key = val;
                b64d_pkg::REG_ADD_KEY: add_key = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] unmasked(logic [7:0] b);
            logic [7:0] diff;
            diff = b - add_key;
            return diff ^ xor_key;
        endfunction

        function void emit(b64d_pkg::kind_t k, logic [7:0] d);
            b64d_pkg::result_t r;
            r.kind = k;
            r.data = d;
            r.last = 1'b0;
            run_buf.push_back(r);
        endfunction

        // returns 1 when the character was not simply ignored
        function bit take_char(logic [7:0] code, logic sot);
            logic [6:0]        sx;
            logic [23:0]       word;
            b64d_pkg::result_t r;
            sx = sextet_value(code);
            if (sot)
            begin
                group_pos = 2'd0;
                sextets   = 18'd0;
                pads      = 2'd0;
                status    = b64d_pkg::ST_ACTIVE;
            end
            if (status != b64d_pkg::ST_ACTIVE)
                return 1'b0;
            run_buf.delete();
            case (group_pos)
                2'd0:
                begin
                    if (sx[6])
                    begin
                        status = b64d_pkg::ST_DONE;
                        emit(b64d_pkg::KIND_END, 8'h00);
                    end
                    else
                    begin
                        sextets   = {12'd0, sx[5:0]};
                        pads      = 2'd0;
                        group_pos = 2'd1;
                    end
                end
                2'd1:
                begin
                    if (sx[6])
                    begin
                        status = b64d_pkg::ST_ERROR;
                        emit(b64d_pkg::KIND_BAD, 8'h00);
                    end
                    else
                    begin
                        sextets   = {sextets[11:0], sx[5:0]};
                        group_pos = 2'd2;
                    end
                end
                2'd2:
                begin
                    if (code == b64d_pkg::PAD_CHAR)
                    begin
                        pads      = 2'd1;
                        sextets   = {sextets[11:0], 6'd0};
                        group_pos = 2'd3;
                    end
                    else if (sx[6])
                    begin
                        status = b64d_pkg::ST_ERROR;
                        emit(b64d_pkg::KIND_BAD, 8'h00);
                    end
                    else
                    begin
                        sextets   = {sextets[11:0], sx[5:0]};
                        group_pos = 2'd3;
                    end
                end
                default:
                begin
                    if (code == b64d_pkg::PAD_CHAR)
                    begin
                        sx   = 7'd0;
                        pads = pads + 2'd1;
                    end
                    // anything but '=' after a pad breaks the group
                    if (code != b64d_pkg::PAD_CHAR && (pads != 2'd0 || sx[6]))
                    begin
                        status = b64d_pkg::ST_ERROR;
                        emit(b64d_pkg::KIND_BAD, 8'h00);
                    end
                    else
                    begin
                        word = {sextets, sx[5:0]};
                        emit(b64d_pkg::KIND_DATA, unmasked(word[23:16]));
                        if (pads < 2'd2)
                            emit(b64d_pkg::KIND_DATA, unmasked(word[15:8]));
                        if (pads < 2'd1)
                            emit(b64d_pkg::KIND_DATA, unmasked(word[7:0]));
                        if (pads != 2'd0)
                        begin
                            status = b64d_pkg::ST_DONE;
                            emit(b64d_pkg::KIND_END, 8'h00);
                        end
                        group_pos = 2'd0;
                        sextets   = 18'd0;
                        pads      = 2'd0;
                    end
                end
            endcase
            foreach (run_buf[i])
            begin
                r      = run_buf[i];
                r.last = (i == run_buf.size() - 1);
                results_due.push_back(r);
            end
            return 1'b1;
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
            b64d_pkg::result_t want;
            if (results_due.size() == 0)
            begin
                $error("result with nothing expected: kind %0d data %02h last %0b",
                       kind, data, last);
                failures++;
                return;
            end
            want = results_due.pop_front();
            if (kind !== want.kind)
            begin
                $error("result_kind: expected %0d, got %0d", want.kind, kind);
                failures++;
            end
            if (data !== want.data)
            begin
                $error("data_byte: expected %02h, got %02h", want.data, data);
                failures++;
            end
            if (last !== want.last)
            begin
                $error("last_of_run: expected %0b, got %0b", want.last, last);
                failures++;
            end
        endfunction

        function int outstanding();
            return results_due.size();
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             char_valid;
    logic                             char_stall;
    logic [7:0]                       char_code;
    logic                             start_of_text;
    logic                             result_valid;
    logic                             result_stall;
    logic [1:0]                       result_kind;
    logic [7:0]                       data_byte;
    logic                             last_of_run;
    logic                             cfg_write_en;
    logic [b64d_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [b64d_pkg::CFG_DATA_W-1:0]  cfg_data;

    decode_scoreboard sb;
    int live_chars   = 0;
    int calm_left    = 0;
    bit text_opening = 1'b0;
    bit hold_armed   = 1'b0;

    base64_deobfuscate_decoder_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_code     (char_code),
        .start_of_text (start_of_text),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_kind   (result_kind),
        .data_byte     (data_byte),
        .last_of_run   (last_of_run),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_kind, data_byte, last_of_run);
    end

    // receiver side: open stretches, short stalls, a few long ones
    initial
    begin
        int pick;
        result_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    result_stall <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
                else if (pick < 95)
                begin
                    result_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    result_stall <= 1'b1;
                    repeat ($urandom_range(10, 30)) @(posedge clk);
                end
            end
        end
    end

    task automatic send_char(logic [7:0] c, logic sot);
        char_valid    <= 1'b1;
        char_code     <= c;
        start_of_text <= sot;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        if (sb.take_char(c, sot))
            live_chars++;
    endtask

    task automatic pace_sender();
        int n;
        int pick;
        n = 0;
        if (calm_left > 0)
            calm_left--;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                calm_left = $urandom_range(20, 60);
            else if (pick < 23)
                n = $urandom_range(1, 3);
            else if (pick < 27)
                n = $urandom_range(8, 25);
        end
        if (n > 0)
        begin
            char_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_text(string s, bit sot_first);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], sot_first && i == 0);
            pace_sender();
        end
    endtask

    // next character of a generated text, the first one carries the start flag
    task automatic send_live(logic [7:0] c);
        send_char(c, text_opening);
        text_opening = 1'b0;
        pace_sender();
    endtask

    function automatic logic [7:0] alpha_char();
        int v;
        v = $urandom_range(0, 63);
        if (v < 26)
            return 8'("A" + v);
        if (v < 52)
            return 8'("a" + v - 26);
        if (v < 62)
            return 8'("0" + v - 52);
        return (v == 62) ? 8'("+") : 8'("/");
    endfunction

    function automatic logic [7:0] junk_char(bit pad_ok);
        logic [7:0] c;
        logic [6:0] s;
        do
        begin
            c = 8'($urandom_range(0, 255));
            s = decode_scoreboard::sextet_value(c);
        end
        while (!s[6] || (!pad_ok && c == b64d_pkg::PAD_CHAR));
        return c;
    endfunction

    task automatic send_random_run();
        int pick;
        int tail;
        int part;
        pick = $urandom_range(0, 99);
        if (pick < 82)
        begin
            text_opening = 1'b1;
            repeat ($urandom_range(0, 5) * 4) send_live(alpha_char());
            tail = $urandom_range(0, 5);
            case (tail)
                0:
                begin
                    send_live(alpha_char());
                    send_live(alpha_char());
                    send_live(b64d_pkg::PAD_CHAR);
                    send_live(b64d_pkg::PAD_CHAR);
                end
                1:
                begin
                    repeat (3) send_live(alpha_char());
                    send_live(b64d_pkg::PAD_CHAR);
                end
                2: send_live(junk_char(1'b1));
                3:
                begin
                    // partial group broken by a bad character
                    part = $urandom_range(1, 3);
                    repeat (part) send_live(alpha_char());
                    send_live(junk_char(part == 1));
                end
                4:
                begin
                    send_live(alpha_char());
                    send_live(alpha_char());
                    send_live(b64d_pkg::PAD_CHAR);
                    send_live(alpha_char());
                end
                default: ;
            endcase
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                pace_sender();
            end
        end
    endtask

    task automatic run_random_texts(int budget);
        int first;
        first = live_chars;
        while (live_chars - first < budget)
            send_random_run();
    endtask

    task automatic settle();
        char_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_keys(logic [7:0] xk, logic [7:0] ak);
        cfg_write_en <= 1'b1;
        cfg_index    <= b64d_pkg::REG_XOR_KEY;
        cfg_data     <= xk;
        @(posedge clk);
        sb.write_reg(b64d_pkg::REG_XOR_KEY, xk);
        cfg_index <= b64d_pkg::REG_ADD_KEY;
        cfg_data  <= ak;
        @(posedge clk);
        sb.write_reg(b64d_pkg::REG_ADD_KEY, ak);
        cfg_index <= REG_SPARE;
        cfg_data  <= ~ak;
        @(posedge clk);
        sb.write_reg(REG_SPARE, ~ak);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n         <= 1'b0;
        char_valid    <= 1'b0;
        char_code     <= 8'h00;
        start_of_text <= 1'b0;
        cfg_write_en  <= 1'b0;
        cfg_index     <= b64d_pkg::REG_XOR_KEY;
        cfg_data      <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset keys
        send_text("+/90", 1'b1);
        send_text("QQ==", 1'b0);     // two pads, one byte then end of text
        send_text("X", 1'b0);        // finished, ignored
        send_text("QUI=", 1'b1);     // one pad, two bytes then end of text
        send_char(8'h00, 1'b1);      // terminator at group start
        send_text("A!", 1'b1);       // bad character in position 1
        send_text("AB=A", 1'b1);     // data after a pad
        send_text("ABC", 1'b1);
        send_char(8'hFF, 1'b0);      // bad character in position 3
        send_text("AB", 1'b1);
        send_char(8'h80, 1'b0);      // bad character in position 2
        send_text("=", 1'b1);
        settle();

        program_keys(8'h00, 8'h00);
        run_random_texts(TEXT_BUDGET);
        settle();

        // receiver holds off while the sender keeps offering transfers
        program_keys(8'hFF, 8'hFF);
        hold_armed = 1'b1;
        calm_left  = 120;
        run_random_texts(TEXT_BUDGET);
        settle();

        program_keys(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random_texts(TEXT_BUDGET);
        settle();

        program_keys(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random_texts(TEXT_BUDGET);
        settle();

        if (sb.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
